/* src/copy_add_delta_decoder_top_assert.svh */
// ----------------------------------------------------------------------------
// copy_add_delta_decoder_top_assert.svh
// assertion macros shared by the checker of the delta decoder
// ----------------------------------------------------------------------------
`ifndef COPY_ADD_DELTA_DECODER_TOP_ASSERT_SVH
`define COPY_ADD_DELTA_DECODER_TOP_ASSERT_SVH

// same-cycle implication, off while reset is high
`define CADD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cadd check failed");

// next-cycle implication, off while reset is high
`define CADD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cadd check failed");

// next-cycle implication that also holds through reset
`define CADD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("cadd check failed");

`endif

/* src/cadd_pkg.sv */
// ----------------------------------------------------------------------------
// cadd_pkg
// shared types and constants of the copy/add delta decoder
// ----------------------------------------------------------------------------
`default_nettype none

package cadd_pkg;

   localparam int unsigned REF_DEPTH = 65536;
   localparam int REF_AW = $clog2(REF_DEPTH);
   localparam int REF_LW = $clog2(REF_DEPTH + 1);
   localparam int NUM_W = 24;
   localparam int CMP_W = (NUM_W > REF_LW) ? NUM_W : REF_LW;

   localparam int QUEUE_DEPTH = 4;
   localparam int Q_AW = $clog2(QUEUE_DEPTH);
   localparam int Q_CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] OP_LOAD    = 3'd0;
   localparam logic [2:0] OP_DELTA   = 3'd1;
   localparam logic [2:0] OP_END     = 3'd2;
   localparam logic [2:0] OP_DRAIN   = 3'd3;
   localparam logic [2:0] OP_RESTART = 3'd4;

   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef enum logic [2:0] {
      KIND_LOAD,
      KIND_DELTA,
      KIND_END,
      KIND_DRAIN,
      KIND_RESTART,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_a;
      logic       is_c;
      logic       is_colon;
      logic       is_comma;
      logic       is_nl;
   } item_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       busy_res;
      logic       copy_last;
      logic [1:0] status;
   } rsp_type;

endpackage

`default_nettype wire

/* src/copy_add_delta_decoder_top.sv */
// ----------------------------------------------------------------------------
// copy_add_delta_decoder_top
// Takes one item per cycle if not full and returns exactly one result beat
// per item, in order. A four-entry request queue classifies items, the
// parser handles one item per cycle if the result queue has room and drives
// the 64 KiB reference store through one write port (loads) and one
// registered read port (drains), and a four-entry result queue decouples
// the consumer. The store needs no clearing pass; reload it after restart.
// ----------------------------------------------------------------------------
`default_nettype none

module copy_add_delta_decoder_top
   import cadd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_data_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_busy_res,
   output logic       rsp_copy_last,
   output logic [1:0] rsp_status
);

   item_type        head;
   logic            avail;
   logic            deq;
   logic            res_push;
   rsp_type         res_data;
   rsp_type         res_head;
   logic [Q_CW-1:0] level;

   cadd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .operation (req_operation),
      .data_byte (req_data_byte),
      .deq       (deq),
      .avail     (avail),
      .head      (head)
   );

   cadd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .avail    (avail),
      .head     (head),
      .level    (level),
      .deq      (deq),
      .rsp_push (res_push),
      .rsp_data (res_data)
   );

   cadd_outq u_outq (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .data_in (res_data),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .head    (res_head),
      .level   (level)
   );

   assign rsp_out_valid = res_head.out_valid;
   assign rsp_out_byte  = res_head.out_byte;
   assign rsp_busy_res  = res_head.busy_res;
   assign rsp_copy_last = res_head.copy_last;
   assign rsp_status    = res_head.status;

endmodule

`default_nettype wire

/* src/cadd_front.sv */
// ----------------------------------------------------------------------------
// cadd_front
// request queue: decodes the operation and classifies the byte on entry
// ----------------------------------------------------------------------------
`default_nettype none

module cadd_front
   import cadd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [2:0] operation,
   input  logic [7:0] data_byte,
   input  logic       deq,
   output logic       avail,
   output item_type   head
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [Q_AW-1:0]     wr_ptr_ff;
   logic [Q_AW-1:0]     wr_ptr_in;
   logic [Q_AW-1:0]     rd_ptr_ff;
   logic [Q_AW-1:0]     rd_ptr_in;
   logic [Q_CW-1:0]     count_ff;
   logic [Q_CW-1:0]     count_in;
   logic                wr_en;
   logic                rd_en;
   item_type            item;

   always_comb begin
      item          = '0;
      item.data     = data_byte;
      item.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
      item.digit    = 4'(data_byte - CH_ZERO);
      item.is_a     = (data_byte == CH_A);
      item.is_c     = (data_byte == CH_C);
      item.is_colon = (data_byte == CH_COLON);
      item.is_comma = (data_byte == CH_COMMA);
      item.is_nl    = (data_byte == CH_NL);
      unique case (operation)
         OP_LOAD: begin
            item.kind = KIND_LOAD;
         end
         OP_DELTA: begin
            item.kind = KIND_DELTA;
         end
         OP_END: begin
            item.kind = KIND_END;
         end
         OP_DRAIN: begin
            item.kind = KIND_DRAIN;
         end
         OP_RESTART: begin
            item.kind = KIND_RESTART;
         end
         default: begin
            item.kind = KIND_NONE;
         end
      endcase
   end

   assign full  = (count_ff == Q_CW'(QUEUE_DEPTH));
   assign avail = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];
   assign wr_en = push && !full;
   assign rd_en = deq && avail;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CW'(wr_en) - Q_CW'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

/* src/cadd_back.sv */
// ----------------------------------------------------------------------------
// cadd_back
// delta parser, reference store and result stage
// ----------------------------------------------------------------------------
`default_nettype none

module cadd_back
   import cadd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            avail,
   input  item_type        head,
   input  logic [Q_CW-1:0] level,
   output logic            deq,
   output logic            rsp_push,
   output rsp_type         rsp_data
);

   localparam int LVL_W = Q_CW + 1;
   localparam int ACC_W = NUM_W + 4;

   typedef enum logic [3:0] {
      PH_CMD,
      PH_CMD_NL,
      PH_A_FIRST,
      PH_A_DIGITS,
      PH_A_LIT,
      PH_C_FIRST,
      PH_C_DIGITS,
      PH_OFF_FIRST,
      PH_OFF_DIGITS,
      PH_COPY
   } phase_type;

   logic [7:0]        store [REF_DEPTH];
   logic [7:0]        rdata_ff;

   logic [REF_LW-1:0] ref_len_ff;
   logic [REF_LW-1:0] ref_len_in;
   phase_type         phase_ff;
   phase_type         phase_in;
   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  num_in;
   logic [NUM_W-1:0]  held_ff;
   logic [NUM_W-1:0]  held_in;
   logic [REF_AW-1:0] caddr_ff;
   logic [REF_AW-1:0] caddr_in;
   logic [REF_LW-1:0] crem_ff;
   logic [REF_LW-1:0] crem_in;
   logic [NUM_W-1:0]  lrem_ff;
   logic [NUM_W-1:0]  lrem_in;
   logic [1:0]        stop_ff;
   logic [1:0]        stop_in;

   logic              s2_valid_ff;
   rsp_type           s2_res_ff;
   rsp_type           s2_res_in;
   logic              s2_mem_ff;
   logic              s2_mem_in;

   logic              fire;
   logic              is_end;
   logic              wr_en;
   logic              rd_en;
   logic [ACC_W-1:0]  acc_wide;
   logic [NUM_W-1:0]  acc_sat;
   logic              off_over;
   logic [REF_LW-1:0] avail_cnt;
   logic [REF_LW-1:0] copy_cnt;
   logic              letter_bad;
   phase_type         letter_phase;

   assign fire = avail && ((LVL_W'(level) + LVL_W'(s2_valid_ff)) < LVL_W'(QUEUE_DEPTH));
   assign deq  = fire;
   assign is_end = (head.kind == KIND_END);

   // saturating decimal accumulate
   always_comb begin
      acc_wide = ACC_W'({num_ff, 3'b000}) + ACC_W'({num_ff, 1'b0}) + ACC_W'(head.digit);
      acc_sat  = (acc_wide[ACC_W-1:NUM_W] != '0) ? '1 : acc_wide[NUM_W-1:0];
   end

   // copy range and clamp
   always_comb begin
      off_over  = CMP_W'(num_ff) > CMP_W'(ref_len_ff);
      avail_cnt = ref_len_ff - REF_LW'(num_ff);
      copy_cnt  = (CMP_W'(held_ff) < CMP_W'(avail_cnt)) ? REF_LW'(held_ff) : avail_cnt;
   end

   // byte in command letter position
   always_comb begin
      letter_bad   = 1'b0;
      letter_phase = phase_ff;
      if (head.is_a) begin
         letter_phase = PH_A_FIRST;
      end else if (head.is_c) begin
         letter_phase = PH_C_FIRST;
      end else if (head.is_nl && (phase_ff != PH_CMD_NL)) begin
         letter_phase = PH_CMD_NL;
      end else begin
         letter_bad = 1'b1;
      end
   end

   always_comb begin
      ref_len_in = ref_len_ff;
      phase_in   = phase_ff;
      num_in     = num_ff;
      held_in    = held_ff;
      caddr_in   = caddr_ff;
      crem_in    = crem_ff;
      lrem_in    = lrem_ff;
      stop_in    = stop_ff;
      s2_res_in  = '0;
      s2_mem_in  = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      if (fire) begin
         unique case (head.kind)
            KIND_LOAD: begin
               if (ref_len_ff != REF_LW'(REF_DEPTH)) begin
                  wr_en      = 1'b1;
                  ref_len_in = ref_len_ff + 1'b1;
               end
            end
            KIND_RESTART: begin
               ref_len_in = '0;
               phase_in   = PH_CMD;
               num_in     = '0;
               held_in    = '0;
               caddr_in   = '0;
               crem_in    = '0;
               lrem_in    = '0;
               stop_in    = ST_RUN;
            end
            KIND_DRAIN: begin
               if ((stop_ff == ST_RUN) && (phase_ff == PH_COPY)) begin
                  rd_en               = 1'b1;
                  s2_mem_in           = 1'b1;
                  s2_res_in.out_valid = 1'b1;
                  caddr_in            = caddr_ff + 1'b1;
                  crem_in             = crem_ff - 1'b1;
                  if (crem_ff == REF_LW'(1)) begin
                     s2_res_in.copy_last = 1'b1;
                     phase_in            = PH_CMD;
                  end
               end
            end
            KIND_DELTA, KIND_END: begin
               if (stop_ff == ST_RUN) begin
                  unique case (phase_ff)
                     PH_COPY: begin
                        s2_res_in.busy_res = 1'b1;
                     end
                     PH_CMD, PH_CMD_NL: begin
                        if (is_end) begin
                           stop_in = ST_DONE;
                        end else if (letter_bad) begin
                           stop_in = ST_BAD;
                        end else begin
                           phase_in = letter_phase;
                        end
                     end
                     PH_A_FIRST, PH_C_FIRST, PH_OFF_FIRST: begin
                        if (!is_end && head.is_digit) begin
                           num_in   = NUM_W'(head.digit);
                           phase_in = phase_type'(phase_ff + 4'd1);
                        end else begin
                           stop_in = ST_BAD;
                        end
                     end
                     PH_A_DIGITS: begin
                        if (!is_end && head.is_digit) begin
                           num_in = acc_sat;
                        end else if (!is_end && head.is_colon) begin
                           lrem_in  = num_ff;
                           num_in   = '0;
                           phase_in = (num_ff != '0) ? PH_A_LIT : PH_CMD;
                        end else begin
                           stop_in = ST_BAD;
                        end
                     end
                     PH_A_LIT: begin
                        if (is_end) begin
                           stop_in = ST_BAD;
                        end else begin
                           s2_res_in.out_valid = 1'b1;
                           s2_res_in.out_byte  = head.data;
                           lrem_in             = lrem_ff - 1'b1;
                           if (lrem_ff == NUM_W'(1)) begin
                              phase_in = PH_CMD;
                           end
                        end
                     end
                     PH_C_DIGITS: begin
                        if (!is_end && head.is_digit) begin
                           num_in = acc_sat;
                        end else if (!is_end && head.is_comma) begin
                           held_in  = num_ff;
                           num_in   = '0;
                           phase_in = PH_OFF_FIRST;
                        end else begin
                           stop_in = ST_BAD;
                        end
                     end
                     PH_OFF_DIGITS: begin
                        if (!is_end && head.is_digit) begin
                           num_in = acc_sat;
                        end else begin
                           num_in = '0;
                           if (off_over) begin
                              stop_in = ST_RANGE;
                           end else if (copy_cnt != '0) begin
                              caddr_in           = num_ff[REF_AW-1:0];
                              crem_in            = copy_cnt;
                              phase_in           = PH_COPY;
                              s2_res_in.busy_res = 1'b1;
                           end else if (is_end) begin
                              phase_in = PH_CMD;
                              stop_in  = ST_DONE;
                           end else if (letter_bad) begin
                              phase_in = PH_CMD;
                              stop_in  = ST_BAD;
                           end else begin
                              phase_in = letter_phase;
                           end
                        end
                     end
                     default: begin
                        stop_in = ST_BAD;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
      s2_res_in.status = stop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff  <= '0;
         phase_ff    <= PH_CMD;
         num_ff      <= '0;
         held_ff     <= '0;
         caddr_ff    <= '0;
         crem_ff     <= '0;
         lrem_ff     <= '0;
         stop_ff     <= ST_RUN;
         s2_valid_ff <= 1'b0;
      end else begin
         ref_len_ff  <= ref_len_in;
         phase_ff    <= phase_in;
         num_ff      <= num_in;
         held_ff     <= held_in;
         caddr_ff    <= caddr_in;
         crem_ff     <= crem_in;
         lrem_ff     <= lrem_in;
         stop_ff     <= stop_in;
         s2_valid_ff <= fire;
      end
      s2_res_ff <= s2_res_in;
      s2_mem_ff <= s2_mem_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[ref_len_ff[REF_AW-1:0]] <= head.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= store[caddr_ff];
      end
   end

   always_comb begin
      rsp_push = s2_valid_ff;
      rsp_data = s2_res_ff;
      if (s2_mem_ff) begin
         rsp_data.out_byte = rdata_ff;
      end
   end

endmodule

`default_nettype wire

/* src/cadd_outq.sv */
// ----------------------------------------------------------------------------
// cadd_outq
// result queue toward the consumer
// ----------------------------------------------------------------------------
`default_nettype none

module cadd_outq
   import cadd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_type         data_in,
   input  logic            pop,
   output logic            empty,
   output rsp_type         head,
   output logic [Q_CW-1:0] level
);

   rsp_type             slot_ff [QUEUE_DEPTH];
   logic [Q_AW-1:0]     wr_ptr_ff;
   logic [Q_AW-1:0]     wr_ptr_in;
   logic [Q_AW-1:0]     rd_ptr_ff;
   logic [Q_AW-1:0]     rd_ptr_in;
   logic [Q_CW-1:0]     count_ff;
   logic [Q_CW-1:0]     count_in;
   logic                rd_en;

   assign empty = (count_ff == '0);
   assign level = count_ff;
   assign head  = slot_ff[rd_ptr_ff];
   assign rd_en = pop && !empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CW'(push) - Q_CW'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

`default_nettype wire

/* src/cadd_checker.sv */
// ----------------------------------------------------------------------------
// cadd_checker
// port-level checks of the delta decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "copy_add_delta_decoder_top_assert.svh"

module cadd_checker
   import cadd_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       req_full,
   input wire       rsp_empty,
   input wire       rsp_pop,
   input wire       rsp_out_valid,
   input wire [7:0] rsp_out_byte,
   input wire       rsp_busy_res,
   input wire       rsp_copy_last,
   input wire [1:0] rsp_status
);

   `CADD_ASSERT_NOW(a_idle_byte_zero, clock, reset, !rsp_empty && !rsp_out_valid, rsp_out_byte == 8'd0)
   `CADD_ASSERT_NOW(a_last_has_byte, clock, reset, !rsp_empty && rsp_copy_last, rsp_out_valid)
   `CADD_ASSERT_NOW(a_busy_running, clock, reset, !rsp_empty && rsp_busy_res,
                    !rsp_out_valid && rsp_status == ST_RUN)
   `CADD_ASSERT_NEXT(a_beat_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty)
   `CADD_ASSERT_ALWAYS_NEXT(a_reset_clears, clock, reset, rsp_empty && !req_full)

endmodule

bind copy_add_delta_decoder_top cadd_checker u_checker (.*);

`default_nettype wire

/* tb/copy_add_delta_decoder_checker.sv */
// ----------------------------------------------------------------------------
// copy_add_delta_decoder_checker
// Watches both queue interfaces of the copy/add delta decoder. It keeps its
// own copy of the decoder state, predicts the result beat of every accepted
// item, and compares each popped beat, field by field, with the oldest
// prediction. It reports the number of failures and the number of
// predictions still waiting.
// ----------------------------------------------------------------------------
module copy_add_delta_decoder_checker
   import cadd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic       rsp_out_valid,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_busy_res,
   input  logic       rsp_copy_last,
   input  logic [1:0] rsp_status,
   output int         fail_count,
   output int         pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      P_LETTER,
      P_LETTER_NL,
      P_ALEN_FIRST,
      P_ALEN,
      P_LITERAL,
      P_CLEN_FIRST,
      P_CLEN,
      P_OFFS_FIRST,
      P_OFFS,
      P_COPYING
   } parse_state_t;

   logic [7:0]        ref_mem [REF_DEPTH];
   logic [REF_LW-1:0] ref_len;
   parse_state_t      parse_st;
   logic [NUM_W-1:0]  num_acc;
   logic [NUM_W-1:0]  copy_len_held;
   logic [REF_AW-1:0] copy_addr;
   logic [REF_LW-1:0] copy_left;
   logic [NUM_W-1:0]  lit_left;
   logic [1:0]        stop_st;

   rsp_type pending_outputs[$];

   function automatic void clear_decoder();
      ref_len       = '0;
      parse_st      = P_LETTER;
      num_acc       = '0;
      copy_len_held = '0;
      copy_addr     = '0;
      copy_left     = '0;
      lit_left      = '0;
      stop_st       = ST_RUN;
   endfunction

   function automatic logic [NUM_W-1:0] next_number(logic [NUM_W-1:0] n, logic [7:0] b);
      logic [31:0] v;
      v = 32'(n) * 10 + 32'(b - CH_ZERO);
      return (v > 32'(24'hFF_FFFF)) ? '1 : v[NUM_W-1:0];
   endfunction

   function automatic void take_letter(logic [7:0] b, bit nl_ok);
      if (b == CH_A) begin
         parse_st = P_ALEN_FIRST;
      end else if (b == CH_C) begin
         parse_st = P_CLEN_FIRST;
      end else if (b == CH_NL && nl_ok) begin
         parse_st = P_LETTER_NL;
      end else begin
         stop_st = ST_BAD;
      end
   endfunction

   // returns 1 when a copy run is now waiting to be drained
   function automatic bit open_copy();
      logic [NUM_W-1:0] off;
      logic [CMP_W-1:0] room;
      logic [CMP_W-1:0] run;
      off = num_acc;
      num_acc = '0;
      if (CMP_W'(off) > CMP_W'(ref_len)) begin
         stop_st = ST_RANGE;
         return 1'b0;
      end
      room = CMP_W'(ref_len) - CMP_W'(off);
      run = (CMP_W'(copy_len_held) < room) ? CMP_W'(copy_len_held) : room;
      if (run == '0) begin
         parse_st = P_LETTER;
         return 1'b0;
      end
      copy_addr = off[REF_AW-1:0];
      copy_left = run[REF_LW-1:0];
      parse_st  = P_COPYING;
      return 1'b1;
   endfunction

   function automatic rsp_type decode_step(logic [2:0] op, logic [7:0] b);
      rsp_type r;
      bit fin;
      bit digit;
      r = '0;
      fin = (op == OP_END);
      digit = !fin && b >= CH_ZERO && b <= CH_NINE;
      if (op == OP_LOAD) begin
         if (ref_len < REF_LW'(REF_DEPTH)) begin
            ref_mem[ref_len[REF_AW-1:0]] = b;
            ref_len = ref_len + 1'b1;
         end
      end else if (op == OP_RESTART) begin
         clear_decoder();
      end else if (op == OP_DRAIN) begin
         if (stop_st == ST_RUN && parse_st == P_COPYING) begin
            r.out_valid = 1'b1;
            r.out_byte  = ref_mem[copy_addr];
            copy_addr   = copy_addr + 1'b1;
            copy_left   = copy_left - 1'b1;
            if (copy_left == '0) begin
               r.copy_last = 1'b1;
               parse_st = P_LETTER;
            end
         end
      end else if ((op == OP_DELTA || fin) && stop_st == ST_RUN) begin
         case (parse_st)
            P_COPYING: r.busy_res = 1'b1;
            P_LETTER, P_LETTER_NL: begin
               if (fin) stop_st = ST_DONE;
               else take_letter(b, parse_st == P_LETTER);
            end
            P_ALEN_FIRST, P_CLEN_FIRST, P_OFFS_FIRST: begin
               if (digit) begin
                  num_acc = NUM_W'(b - CH_ZERO);
                  if (parse_st == P_ALEN_FIRST) parse_st = P_ALEN;
                  else if (parse_st == P_CLEN_FIRST) parse_st = P_CLEN;
                  else parse_st = P_OFFS;
               end else begin
                  stop_st = ST_BAD;
               end
            end
            P_ALEN: begin
               if (digit) begin
                  num_acc = next_number(num_acc, b);
               end else if (!fin && b == CH_COLON) begin
                  lit_left = num_acc;
                  num_acc  = '0;
                  parse_st = (lit_left != '0) ? P_LITERAL : P_LETTER;
               end else begin
                  stop_st = ST_BAD;
               end
            end
            P_LITERAL: begin
               if (fin) begin
                  stop_st = ST_BAD;
               end else begin
                  r.out_valid = 1'b1;
                  r.out_byte  = b;
                  lit_left    = lit_left - 1'b1;
                  if (lit_left == '0) parse_st = P_LETTER;
               end
            end
            P_CLEN: begin
               if (digit) begin
                  num_acc = next_number(num_acc, b);
               end else if (!fin && b == CH_COMMA) begin
                  copy_len_held = num_acc;
                  num_acc  = '0;
                  parse_st = P_OFFS_FIRST;
               end else begin
                  stop_st = ST_BAD;
               end
            end
            P_OFFS: begin
               if (digit) begin
                  num_acc = next_number(num_acc, b);
               end else if (open_copy()) begin
                  r.busy_res = 1'b1;
               end else if (stop_st == ST_RUN) begin
                  if (fin) stop_st = ST_DONE;
                  else take_letter(b, 1'b1);
               end
            end
            default: stop_st = ST_BAD;
         endcase
      end
      r.status = stop_st;
      return r;
   endfunction

   task automatic compare_field(input string label, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_decoder();
         pending_outputs.delete();
         fail_count = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_outputs.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat, expected none, actual byte %0d status %0d",
                        $time, rsp_out_byte, rsp_status);
            end else begin
               want = pending_outputs.pop_front();
               compare_field("out_valid", want.out_valid, rsp_out_valid);
               compare_field("out_byte", want.out_byte, rsp_out_byte);
               compare_field("busy_res", want.busy_res, rsp_busy_res);
               compare_field("copy_last", want.copy_last, rsp_copy_last);
               compare_field("status", want.status, rsp_status);
            end
         end
         if (req_push && !req_full) begin
            pending_outputs.push_back(decode_step(req_operation, req_data_byte));
         end
      end
      pending_count = pending_outputs.size();
   end

endmodule

/* tb/tb_copy_add_delta_decoder_top.sv */
// ----------------------------------------------------------------------------
// tb_copy_add_delta_decoder_top
// Drives the copy/add delta decoder with a directed opening, a short reference
// store with clamped copies, and random delta streams: literal and copy
// commands with random content, pending copies drained and resent, plus
// malformed and out-of-range streams and random noise. Both sides stall at
// random. A checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_copy_add_delta_decoder_top;

   import cadd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam longint unsigned NUM_SAT = 64'hFF_FFFF;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [2:0] req_operation;
   logic [7:0] req_data_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic       rsp_out_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_busy_res;
   logic       rsp_copy_last;
   logic [1:0] rsp_status;

   int fail_count;
   int pending_count;
   bit calm;
   int beats;
   int ref_len_seen;
   int owed;

   copy_add_delta_decoder_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_copy_last (rsp_copy_last),
      .rsp_status    (rsp_status)
   );

   copy_add_delta_decoder_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_copy_last (rsp_copy_last),
      .rsp_status    (rsp_status),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_pop <= !reset && (calm || $urandom_range(99) >= 15);
   end

   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // entered and left at a falling edge, push stays high after the beat
   task automatic send_beat(input logic [2:0] op, input logic [7:0] b);
      bit taken;
      while (!calm && $urandom_range(99) < 15) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_operation <= op;
      req_data_byte <= b;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_full;
         @(negedge clock);
      end
      beats++;
   endtask

   task automatic settle();
      req_push <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic send_number(input longint unsigned v);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) send_beat(OP_DELTA, s[i]);
   endtask

   // first beat of a command or the end beat; a pending copy refuses it
   task automatic start_command(input logic [2:0] op, input logic [7:0] b);
      if (owed > 0) begin
         send_beat(op, b);
         if ($urandom_range(3) == 0) send_beat(OP_DELTA, 8'($urandom_range(255)));
         repeat (owed) send_beat(OP_DRAIN, 8'($urandom_range(255)));
         owed = 0;
         if ($urandom_range(5) == 0) send_beat(OP_DRAIN, 8'($urandom_range(255)));
      end
      send_beat(op, b);
   endtask

   task automatic load_bytes(input int n);
      repeat (n) begin
         send_beat(OP_LOAD, 8'($urandom_range(255)));
         if (ref_len_seen < REF_DEPTH) ref_len_seen++;
      end
   endtask

   task automatic open_command(input logic [7:0] letter, input bit nl);
      if (nl) begin
         start_command(OP_DELTA, CH_NL);
         send_beat(OP_DELTA, letter);
      end else begin
         start_command(OP_DELTA, letter);
      end
      if ($urandom_range(7) == 0) send_beat(OP_DELTA, CH_ZERO);
   endtask

   task automatic literal_command(input int n, input bit nl);
      open_command(CH_A, nl);
      send_number(64'(n));
      send_beat(OP_DELTA, CH_COLON);
      repeat (n) send_beat(OP_DELTA, 8'($urandom_range(255)));
   endtask

   task automatic copy_command(input longint unsigned len, input longint unsigned off,
                               input bit nl, output bit dead);
      longint unsigned l_eff;
      longint unsigned o_eff;
      open_command(CH_C, nl);
      send_number(len);
      send_beat(OP_DELTA, CH_COMMA);
      send_number(off);
      l_eff = (len > NUM_SAT) ? NUM_SAT : len;
      o_eff = (off > NUM_SAT) ? NUM_SAT : off;
      dead = o_eff > ref_len_seen;
      if (dead) owed = 0;
      else owed = int'((l_eff < ref_len_seen - o_eff) ? l_eff : ref_len_seen - o_eff);
   endtask

   task automatic run_stream();
      int ncmd;
      int pick;
      int tail;
      bit dead;
      longint unsigned len;
      longint unsigned off;
      send_beat(OP_RESTART, 8'($urandom_range(255)));
      ref_len_seen = 0;
      owed = 0;
      dead = 1'b0;
      load_bytes(($urandom_range(9) == 0) ? 0 : $urandom_range(40, 1));
      ncmd = $urandom_range(6, 1);
      for (int k = 0; k < ncmd && !dead; k++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            load_bytes(1);
         end else if (pick < 11 && owed == 0) begin
            send_beat(OP_DRAIN, 8'($urandom_range(255)));
         end else if (pick < 15) begin
            send_beat(3'($urandom_range(7)), 8'($urandom_range(255)));
            dead = 1'b1;
         end else if (pick < 18) begin
            start_command(OP_DELTA, CH_NL);
            send_beat(OP_DELTA, CH_NL);
            dead = 1'b1;
         end else if (pick < 22) begin
            start_command(OP_DELTA, 8'($urandom_range(255)));
            dead = 1'b1;
         end else if (pick < 26) begin
            open_command(($urandom_range(1) == 0) ? CH_A : CH_C, 1'b0);
            send_beat(OP_DELTA, 8'($urandom_range(255)));
            send_beat(OP_DELTA, 8'($urandom_range(255)));
            dead = 1'b1;
         end else if (pick < 60) begin
            literal_command(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8),
                            $urandom_range(4) == 0);
         end else begin
            pick = $urandom_range(9);
            len = (pick == 0) ? 64'($urandom_range(99999999, 16777216))
                              : 64'($urandom_range(ref_len_seen + 3));
            pick = $urandom_range(9);
            if (pick == 0) off = 64'($urandom_range(99999999, 16777216));
            else if (pick == 1) off = 64'(ref_len_seen + $urandom_range(3, 1));
            else off = 64'($urandom_range(ref_len_seen));
            copy_command(len, off, $urandom_range(4) == 0, dead);
         end
      end
      tail = $urandom_range(9);
      if (tail == 0) begin
         open_command(CH_A, 1'b0);
         send_number(64'($urandom_range(99, 1)));
         send_beat(OP_END, 8'($urandom_range(255)));
      end else if (tail == 1) begin
         open_command(CH_A, 1'b0);
         send_number(3);
         send_beat(OP_DELTA, CH_COLON);
         send_beat(OP_DELTA, 8'($urandom_range(255)));
         send_beat(OP_END, 8'($urandom_range(255)));
      end else begin
         start_command(OP_END, 8'($urandom_range(255)));
      end
      if ($urandom_range(2) == 0) begin
         repeat ($urandom_range(3, 1)) send_beat(OP_DELTA, 8'($urandom_range(255)));
      end
      owed = 0;
   endtask

   initial begin
      int mark;
      int idx;
      bit dead;
      clock         = 1'b0;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_operation = OP_LOAD;
      req_data_byte = 8'h00;
      rsp_pop       = 1'b0;
      calm          = 1'b0;
      beats         = 0;
      ref_len_seen  = 0;
      owed          = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening: extreme bytes, newline, clamped copy, empty copy
      send_beat(OP_LOAD, 8'h00);
      send_beat(OP_LOAD, 8'hFF);
      send_beat(OP_LOAD, 8'h55);
      send_beat(OP_LOAD, 8'hAA);
      ref_len_seen = 4;
      start_command(OP_DELTA, CH_NL);
      send_beat(OP_DELTA, CH_A);
      send_number(2);
      send_beat(OP_DELTA, CH_COLON);
      send_beat(OP_DELTA, 8'h00);
      send_beat(OP_DELTA, 8'hFF);
      copy_command(9, 1, 1'b0, dead);
      copy_command(2, 4, 1'b1, dead);
      start_command(OP_DELTA, CH_A);
      send_number(0);
      send_beat(OP_DELTA, CH_COLON);
      start_command(OP_END, 8'h00);
      send_beat(OP_DELTA, CH_A);
      send_beat(OP_UNUSED, 8'h00);
      send_beat(OP_DRAIN, 8'h00);

      // short store, then clamped copies at its top end
      calm <= 1'b1;
      send_beat(OP_RESTART, 8'h00);
      ref_len_seen = 0;
      owed = 0;
      load_bytes(24);
      copy_command(99999999, 18, 1'b0, dead);
      copy_command(3, 24, 1'b0, dead);
      start_command(OP_END, 8'h00);
      settle();
      calm <= 1'b0;

      mark = beats;
      idx = 0;
      while (beats - mark < 620) begin
         calm <= (idx % 9 == 4);
         run_stream();
         if (idx % 5 == 2) settle();
         idx++;
      end

      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
